/* src/afmlt_pkg.sv */
// Shared constants, payload types and register codes for the frame level tracker.
package afmlt_pkg;

   // Frame length limit and the widths that follow from it
   localparam int FRAME_SAMPLES = 640;
   localparam int COUNT_W       = $clog2(FRAME_SAMPLES + 1);
   localparam logic [COUNT_W-1:0] FRAME_LEN = COUNT_W'(FRAME_SAMPLES);

   localparam int SAMPLE_W   = 16;
   localparam int SQ_W       = 2 * SAMPLE_W - 1;      // square of a sample is at most 2^30
   localparam int ENERGY_W   = SQ_W - 1 + COUNT_W;    // sum of up to FRAME_SAMPLES squares
   localparam int QUOT_W     = SQ_W;                  // energy / n never exceeds one square
   localparam int ROOT_ACC_W = QUOT_W + 1;
   localparam int DIV_CNT_W  = $clog2(ENERGY_W);

   localparam int RMS_W      = 16;
   localparam int LEVEL_W    = 2;
   localparam int OPEN_SHIFT = 8;
   localparam int OPEN_W     = LEVEL_W + OPEN_SHIFT;
   localparam int THR_W      = 16;

   // Divide by three as multiply by 683 and shift by 11, exact below 2048
   localparam int DIV3_SHIFT = 11;
   localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = 11'd683;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 2'd3;

   // Frame queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RISE_ONE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_TWO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_THREE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_ONE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_TWO   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_THREE = 3'd5;

   localparam logic [THR_W-1:0] RISE_ONE_RST   = 16'd300;
   localparam logic [THR_W-1:0] RISE_TWO_RST   = 16'd950;
   localparam logic [THR_W-1:0] RISE_THREE_RST = 16'd2300;
   localparam logic [THR_W-1:0] FALL_ONE_RST   = 16'd180;
   localparam logic [THR_W-1:0] FALL_TWO_RST   = 16'd650;
   localparam logic [THR_W-1:0] FALL_THREE_RST = 16'd1650;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pcm_sample;
      logic                       frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] mouth_level;
      logic [OPEN_W-1:0]  openness_q8;
      logic [RMS_W-1:0]   smoothed_rms;
   } rsp_payload_type;

   // One closed frame: summed energy and sample count
   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [COUNT_W-1:0]  count;
   } frame_type;

   // Hysteresis thresholds; entry k serves the step between level k and k+1
   typedef struct packed {
      logic [2:0][THR_W-1:0] rise;
      logic [2:0][THR_W-1:0] fall;
   } thr_type;

endpackage

/* src/audio_frame_mouth_level_tracker.sv */
// Top level of the frame level tracker: register file, front end, queue, back end.
//
//  channel | direction | handshake            | carries
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_stall  | pcm_sample, frame_end
//  rsp     | out       | rsp_valid/rsp_stall  | mouth_level, openness_q8, smoothed_rms
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Samples are taken one per cycle while req_stall is low; the front end squares and sums them in three stages.
// A closed frame waits in a four-entry queue; the back end runs it through a divider and a
// square root, one bit per cycle, then through averaging, hysteresis and openness.
// A finished result sits in an output register while the back end takes the next frame.
// Reset (synchronous) clears all frame state and loads the default thresholds.
// req_stall rises only when the queue could fill; csr_ready is always high.
module audio_frame_mouth_level_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  afmlt_pkg::req_payload_type         req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output afmlt_pkg::rsp_payload_type         rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [afmlt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [afmlt_pkg::CSR_DATA_W-1:0]   csr_data
);
   import afmlt_pkg::*;

   thr_type           thr_ff;
   logic              push, pop, q_valid;
   frame_type         push_data, q_data;
   logic [QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   // Threshold registers; writes beyond the last index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.rise[0] <= RISE_ONE_RST;
         thr_ff.rise[1] <= RISE_TWO_RST;
         thr_ff.rise[2] <= RISE_THREE_RST;
         thr_ff.fall[0] <= FALL_ONE_RST;
         thr_ff.fall[1] <= FALL_TWO_RST;
         thr_ff.fall[2] <= FALL_THREE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RISE_ONE:   thr_ff.rise[0] <= csr_data;
            CSR_RISE_TWO:   thr_ff.rise[1] <= csr_data;
            CSR_RISE_THREE: thr_ff.rise[2] <= csr_data;
            CSR_FALL_ONE:   thr_ff.fall[0] <= csr_data;
            CSR_FALL_TWO:   thr_ff.fall[1] <= csr_data;
            CSR_FALL_THREE: thr_ff.fall[2] <= csr_data;
            default: ;
         endcase
      end
   end

   afmlt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_count     (q_count),
      .push        (push),
      .push_data   (push_data)
   );

   afmlt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   afmlt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (pop),
      .thr         (thr_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/afmlt_front.sv */
// Sample front end: squares samples, sums frame energy and closes frames.
module afmlt_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  afmlt_pkg::req_payload_type  req_payload,
   input  logic [afmlt_pkg::QCNT_W-1:0] q_count,
   output logic                        push,
   output afmlt_pkg::frame_type        push_data
);
   import afmlt_pkg::*;

   logic                       a_valid_ff, a_valid_in;
   logic signed [SAMPLE_W-1:0] a_sample_ff;
   logic                       a_end_ff;
   logic                       b_valid_ff, b_valid_in;
   logic [SQ_W-1:0]            b_sq_ff;
   logic                       b_end_ff;
   logic [ENERGY_W-1:0]        energy_ff, energy_in;
   logic [COUNT_W-1:0]         count_ff, count_in;

   logic                       req_accept;
   logic signed [2*SAMPLE_W-1:0] square;
   logic [QCNT_W:0]            occupancy;
   logic [ENERGY_W-1:0]        energy_sum;
   logic [COUNT_W-1:0]         count_next;
   logic                       close;

   // Stall while every queue slot may be claimed by items already in flight
   assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(a_valid_ff)
                      + (QCNT_W+1)'(b_valid_ff);
   assign req_stall  = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;

   assign square = a_sample_ff * a_sample_ff;

   // Accumulate and detect frame close
   assign energy_sum = energy_ff + ENERGY_W'(b_sq_ff);
   assign count_next = count_ff + 1'b1;
   assign close      = b_end_ff || (count_next == FRAME_LEN);

   always_comb begin
      a_valid_in = req_accept;
      b_valid_in = a_valid_ff;
      energy_in  = energy_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_data.energy = energy_sum;
      push_data.count  = count_next;
      if (b_valid_ff) begin
         if (close) begin
            push      = 1'b1;
            energy_in = '0;
            count_in  = '0;
         end else begin
            energy_in = energy_sum;
            count_in  = count_next;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         energy_ff  <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         energy_ff  <= energy_in;
         count_ff   <= count_in;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_sample_ff <= req_payload.pcm_sample;
         a_end_ff    <= req_payload.frame_end;
      end
      b_sq_ff  <= square[SQ_W-1:0];
      b_end_ff <= a_end_ff;
   end

endmodule

/* src/afmlt_queue.sv */
// Short frame queue between the sample front end and the frame back end.
module afmlt_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  afmlt_pkg::frame_type         push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output afmlt_pkg::frame_type         out_data,
   output logic [afmlt_pkg::QCNT_W-1:0] count
);
   import afmlt_pkg::*;

   frame_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && out_valid;

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (!push && do_pop) count_ff <= count_ff - 1'b1;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* src/afmlt_back.sv */
// Frame back end: divide, square root, averaging, level hysteresis and openness.
module afmlt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  afmlt_pkg::frame_type        q_data,
   output logic                        q_pop,
   input  afmlt_pkg::thr_type          thr,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output afmlt_pkg::rsp_payload_type  rsp_payload
);
   import afmlt_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_SQRT  = 7'b0000100,
      ST_EMA   = 7'b0001000,
      ST_LEVEL = 7'b0010000,
      ST_OPEN  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [ENERGY_W-1:0]  div_q_ff, div_q_in;
   logic [COUNT_W-1:0]   div_rem_ff, div_rem_in;
   logic [COUNT_W-1:0]   div_n_ff, div_n_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [QUOT_W-1:0]    sq_v_ff, sq_v_in;
   logic [ROOT_ACC_W-1:0] sq_root_ff, sq_root_in;
   logic [QUOT_W-1:0]    sq_bit_ff, sq_bit_in;
   logic [RMS_W-1:0]     rms_ff, rms_in;
   logic [RMS_W-1:0]     avg_ff, avg_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [OPEN_W-1:0]    open_ff, open_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic [COUNT_W:0]     div_trial, div_diff;
   logic                 div_ge;
   logic [ENERGY_W-1:0]  div_q_next;
   logic [ROOT_ACC_W-1:0] sq_sum, sq_root_next;
   logic                 sq_ge;
   logic [RMS_W+2:0]     ema_sum;
   logic [THR_W-1:0]     rise_sel, fall_sel;
   logic                 rise_ok, fall_ok;
   logic [OPEN_W-1:0]    target, rise_delta, fall_delta, fall_step, open_next;
   logic [OPEN_W:0]      rise_step;
   logic [OPEN_W+DIV3_SHIFT-1:0] fall_prod;
   logic                 rsp_free;

   // One restoring division step: energy / n
   assign div_trial  = {div_rem_ff, div_q_ff[ENERGY_W-1]};
   assign div_ge     = div_trial >= {1'b0, div_n_ff};
   assign div_diff   = div_trial - {1'b0, div_n_ff};
   assign div_q_next = {div_q_ff[ENERGY_W-2:0], div_ge};

   // One square root step, two radicand bits per cycle
   assign sq_sum       = sq_root_ff + ROOT_ACC_W'(sq_bit_ff);
   assign sq_ge        = ROOT_ACC_W'(sq_v_ff) >= sq_sum;
   assign sq_root_next = sq_ge ? (sq_root_ff >> 1) + ROOT_ACC_W'(sq_bit_ff)
                               : (sq_root_ff >> 1);

   // Average: (5 * old + 3 * rms) / 8
   assign ema_sum = ((RMS_W+3)'(avg_ff) << 2) + (RMS_W+3)'(avg_ff)
                    + ((RMS_W+3)'(rms_ff) << 1) + (RMS_W+3)'(rms_ff);

   // Pick the thresholds that apply to the current level
   always_comb begin
      rise_sel = '0;
      fall_sel = '0;
      case (level_ff)
         2'd0: rise_sel = thr.rise[0];
         2'd1: begin
            rise_sel = thr.rise[1];
            fall_sel = thr.fall[0];
         end
         2'd2: begin
            rise_sel = thr.rise[2];
            fall_sel = thr.fall[1];
         end
         default: fall_sel = thr.fall[2];
      endcase
   end

   assign rise_ok = (level_ff != LEVEL_MAX) && (avg_ff >= rise_sel);
   assign fall_ok = (level_ff != '0) && (avg_ff < fall_sel);

   // Openness: fast attack, slow release toward level * 256
   assign target     = {level_ff, {OPEN_SHIFT{1'b0}}};
   assign rise_delta = target - open_ff;
   assign rise_step  = ((OPEN_W+1)'(rise_delta) + 1'b1) >> 1;
   assign fall_delta = open_ff - target;
   assign fall_prod  = fall_delta * DIV3_RECIP;
   assign fall_step  = fall_prod[OPEN_W+DIV3_SHIFT-1:DIV3_SHIFT];
   assign open_next  = (target > open_ff) ? open_ff + rise_step[OPEN_W-1:0]
                                          : open_ff - fall_step;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      div_n_in     = div_n_ff;
      div_cnt_in   = div_cnt_ff;
      sq_v_in      = sq_v_ff;
      sq_root_in   = sq_root_ff;
      sq_bit_in    = sq_bit_ff;
      rms_in       = rms_ff;
      avg_in       = avg_ff;
      level_in     = level_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               div_q_in   = q_data.energy;
               div_n_in   = q_data.count;
               div_rem_in = '0;
               div_cnt_in = DIV_CNT_W'(ENERGY_W - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_q_in   = div_q_next;
            div_rem_in = div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               sq_v_in    = div_q_next[QUOT_W-1:0];
               sq_root_in = '0;
               sq_bit_in  = {1'b1, {(QUOT_W-1){1'b0}}};
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_v_in    = sq_ge ? sq_v_ff - sq_sum[QUOT_W-1:0] : sq_v_ff;
            sq_root_in = sq_root_next;
            sq_bit_in  = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               rms_in   = sq_root_next[RMS_W-1:0];
               state_in = ST_EMA;
            end
         end
         ST_EMA: begin
            avg_in   = ema_sum[RMS_W+2:3];
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            if (rise_ok) level_in = level_ff + 1'b1;
            else if (fall_ok) level_in = level_ff - 1'b1;
            state_in = ST_OPEN;
         end
         ST_OPEN: begin
            open_in  = open_next;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.mouth_level  = level_ff;
               rsp_data_in.openness_q8  = open_ff;
               rsp_data_in.smoothed_rms = avg_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= '0;
         level_ff     <= '0;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         level_ff     <= level_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      div_n_ff    <= div_n_in;
      sq_v_ff     <= sq_v_in;
      sq_root_ff  <= sq_root_in;
      sq_bit_ff   <= sq_bit_in;
      rms_ff      <= rms_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* src/afmlt_checker.sv */
// Port-level checks for the frame level tracker, bound to its top level.
module afmlt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input afmlt_pkg::rsp_payload_type         rsp_payload
);
   import afmlt_pkg::*;

   logic [LEVEL_W:0] last_level_ff;
   logic [LEVEL_W:0] level_now;

   assign level_now = (LEVEL_W+1)'(rsp_payload.mouth_level);

   // Hold the level of the last transferred result
   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_level_ff <= level_now;
      end
   end

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // The level moves by at most one step from one result to the next
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (level_now == last_level_ff) || (level_now == last_level_ff + 1'b1)
                    || (level_now + 1'b1 == last_level_ff))
      else $error("level jumped by more than one step");

   // Openness stays within three levels in Q8
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.openness_q8 <= OPEN_W'(768))
      else $error("openness out of range");

   // The average rms cannot exceed full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.smoothed_rms <= RMS_W'(32768))
      else $error("smoothed rms out of range");

   // No result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind audio_frame_mouth_level_tracker afmlt_checker u_checker (.*);

/* tb/audio_frame_mouth_level_tracker_test.sv */
// Self-checking testbench for the frame level tracker: random sample streams, threshold sweeps.
`timescale 1ns / 1ps

module audio_frame_mouth_level_tracker_test;
   import afmlt_pkg::*;

   localparam int SETTLE_CYCLES = 200;   // back end pass plus queue drain, with margin
   localparam int HOLD_CYCLES   = 500;   // long receiver hold-off to back up the frame queue
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_SAMPLES = 18;
   localparam int FULL_SCALE    = 32768;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   audio_frame_mouth_level_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Samples waiting to be sent and frame results waiting to come back
   req_payload_type pending_samples[$];
   rsp_payload_type expected_frames[$];
   int              mismatch_count = 0;

   // Tracker state as predicted
   longint unsigned frame_energy;
   int unsigned     frame_count;
   int unsigned     rms_average;
   int unsigned     level_now;
   int unsigned     openness_now;
   int unsigned     rise_limit[3];
   int unsigned     fall_limit[3];

   int unsigned cycle_count = 0;
   logic        calm;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          loudness = 100;

   // No random idling on either side inside this window
   assign calm = (cycle_count >= 3000) && (cycle_count < 4200);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int unsigned square_root(input longint unsigned value);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > value) probe = probe >> 2;
      while (probe != 0) begin
         if (value >= root + probe) begin
            value = value - (root + probe);
            root  = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return int'(root);
   endfunction

   function automatic void load_default_thresholds();
      rise_limit[0] = 32'(RISE_ONE_RST);
      rise_limit[1] = 32'(RISE_TWO_RST);
      rise_limit[2] = 32'(RISE_THREE_RST);
      fall_limit[0] = 32'(FALL_ONE_RST);
      fall_limit[1] = 32'(FALL_TWO_RST);
      fall_limit[2] = 32'(FALL_THREE_RST);
   endfunction

   function automatic void apply_threshold(input logic [CSR_IDX_W-1:0] index,
                                           input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_RISE_ONE:   rise_limit[0] = 32'(value);
         CSR_RISE_TWO:   rise_limit[1] = 32'(value);
         CSR_RISE_THREE: rise_limit[2] = 32'(value);
         CSR_FALL_ONE:   fall_limit[0] = 32'(value);
         CSR_FALL_TWO:   fall_limit[1] = 32'(value);
         CSR_FALL_THREE: fall_limit[2] = 32'(value);
         default: ;
      endcase
   endfunction

   // Accumulate one sample; on frame close, queue the level, openness and average
   function automatic void track_sample(input req_payload_type item);
      int              sample;
      int unsigned     count_next;
      int unsigned     frame_rms;
      int unsigned     target;
      rsp_payload_type result;
      sample       = int'($signed(item.pcm_sample));
      frame_energy = frame_energy + longint'(sample * sample);
      count_next   = frame_count + 1;
      if (!item.frame_end && count_next < FRAME_SAMPLES) begin
         frame_count = count_next;
         return;
      end
      frame_rms    = square_root(frame_energy / count_next);
      frame_energy = 0;
      frame_count  = 0;
      rms_average  = (rms_average * 5 + frame_rms * 3) / 8;
      // a rise, when it applies, wins over a fall
      if (level_now < 3 && rms_average >= rise_limit[level_now])
         level_now = level_now + 1;
      else if (level_now > 0 && rms_average < fall_limit[level_now - 1])
         level_now = level_now - 1;
      target = level_now * 256;
      if (target > openness_now)
         openness_now = openness_now + (target - openness_now + 1) / 2;
      else
         openness_now = openness_now - (openness_now - target) / 3;
      result.mouth_level  = level_now[LEVEL_W-1:0];
      result.openness_q8  = openness_now[OPEN_W-1:0];
      result.smoothed_rms = rms_average[RMS_W-1:0];
      expected_frames.push_back(result);
   endfunction

   function automatic void note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   // Sample driver: hold a stalled transfer, otherwise offer the next sample or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) track_sample(req_payload);
         if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: serve long hold-offs on request, otherwise stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 31);
      end
   end

   // Result monitor: compare each transfer with the oldest expected frame
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            note_mismatch("unexpected result, level", -1, int'(rsp_payload.mouth_level));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_payload.mouth_level !== want.mouth_level)
               note_mismatch("mouth_level", int'(want.mouth_level),
                             int'(rsp_payload.mouth_level));
            if (rsp_payload.openness_q8 !== want.openness_q8)
               note_mismatch("openness_q8", int'(want.openness_q8),
                             int'(rsp_payload.openness_q8));
            if (rsp_payload.smoothed_rms !== want.smoothed_rms)
               note_mismatch("smoothed_rms", int'(want.smoothed_rms),
                             int'(rsp_payload.smoothed_rms));
         end
      end
   end

   task automatic write_threshold(input logic [CSR_IDX_W-1:0] index,
                                  input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_threshold(index, value);
   endtask

   task automatic write_all_thresholds(input int r1, input int r2, input int r3,
                                       input int f1, input int f2, input int f3);
      write_threshold(CSR_RISE_ONE,   r1[15:0]);
      write_threshold(CSR_RISE_TWO,   r2[15:0]);
      write_threshold(CSR_RISE_THREE, r3[15:0]);
      write_threshold(CSR_FALL_ONE,   f1[15:0]);
      write_threshold(CSR_FALL_TWO,   f2[15:0]);
      write_threshold(CSR_FALL_THREE, f3[15:0]);
   endtask

   // Wait until every sample is sent and every frame result is back, then drain
   task automatic settle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_frames.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_sample(input int value, input bit closes);
      req_payload_type item;
      item.pcm_sample = value[15:0];
      item.frame_end  = closes;
      pending_samples.push_back(item);
   endfunction

   // Queue a frame of random samples within +/- amplitude; full scale uses all 16 bits
   function automatic void push_frame(input int length, input int amplitude, input bit closes);
      int value;
      for (int k = 0; k < length; k++) begin
         if (amplitude >= FULL_SCALE) value = $urandom;
         else value = int'($urandom_range(2 * amplitude)) - amplitude;
         push_sample(value, closes && (k == length - 1));
      end
   endfunction

   function automatic int random_threshold();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 0;
      if (pick == 1) return 65535;
      if (pick == 2) return $urandom_range(65535);
      return $urandom_range(4000);
   endfunction

   function automatic int next_loudness();
      int pick;
      if ($urandom_range(9) < 6) return loudness;
      pick = $urandom_range(5);
      case (pick)
         0: return 20;
         1: return 300;
         2: return 1200;
         3: return 3000;
         4: return 9000;
         default: return FULL_SCALE;
      endcase
   endfunction

   // Stimulus phases
   initial begin
      int sent;
      int length;
      frame_energy = 0;
      frame_count  = 0;
      rms_average  = 0;
      level_now    = 0;
      openness_now = 0;
      load_default_thresholds();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default thresholds: full-scale single samples drive the level up, silence down
      push_sample(32767, 1'b1);
      push_sample(-32768, 1'b1);
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(0, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(1, 1'b1);
      for (int k = 0; k < 6; k++) push_sample(0, 1'b1);
      push_sample(200, 1'b0);
      push_sample(-200, 1'b0);
      push_sample(150, 1'b0);
      push_sample(-150, 1'b1);
      push_sample(1, 1'b1);
      push_sample(-1, 1'b1);
      settle();

      // Rise thresholds at zero, fall at maximum: a rise wins every frame below the top level
      write_all_thresholds(0, 0, 0, 65535, 65535, 65535);
      @(negedge clock);
      for (int k = 0; k < 5; k++) push_sample(0, 1'b1);
      settle();

      // Rise unreachable, fall at maximum: the level steps down to zero
      write_all_thresholds(65535, 65535, 65535, 65535, 65535, 65535);
      @(negedge clock);
      for (int k = 0; k < 4; k++) push_sample(32767, 1'b1);
      settle();

      // Rise one and falls at zero: level steps to one and holds; unused indexes are ignored
      write_all_thresholds(0, 65535, 65535, 0, 0, 0);
      write_threshold(3'd6, 16'hFFFF);
      write_threshold(3'd7, 16'h0000);
      @(negedge clock);
      push_sample(-32768, 1'b1);
      push_sample(0, 1'b1);
      push_sample(12345, 1'b1);
      settle();

      // Default thresholds, then random ones; short frames with persistent loudness
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            write_all_thresholds(int'(RISE_ONE_RST), int'(RISE_TWO_RST),
                                 int'(RISE_THREE_RST), int'(FALL_ONE_RST),
                                 int'(FALL_TWO_RST), int'(FALL_THREE_RST));
         else
            write_all_thresholds(random_threshold(), random_threshold(), random_threshold(),
                                 random_threshold(), random_threshold(), random_threshold());
         if (phase == 2) write_threshold(3'd6, 16'($urandom));
         @(negedge clock);
         sent = 0;
         while (sent < PHASE_SAMPLES) begin
            loudness = next_loudness();
            length = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            // now and then a frame runs on into the next one
            push_frame(length, loudness, $urandom_range(14) != 0);
            sent += length;
         end
         push_sample($urandom, 1'b1);
         if (phase == 1 || phase == 3) hold_requests = hold_requests + 1;
         settle();
      end

      // Longest frame at default thresholds: the frame length limit closes it without a flag
      write_all_thresholds(int'(RISE_ONE_RST), int'(RISE_TWO_RST),
                           int'(RISE_THREE_RST), int'(FALL_ONE_RST),
                           int'(FALL_TWO_RST), int'(FALL_THREE_RST));
      @(negedge clock);
      for (int k = 0; k < FRAME_SAMPLES; k++) push_sample(-32768, 1'b0);
      push_sample(-32768, 1'b1);
      push_frame(7, 20, 1'b1);
      settle();

      if (mismatch_count == 0 && expected_frames.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
